[hw/rtl/lslb_pkg.sv]
// lslb_pkg: types, constants and helper function of the link status LED blinker
// no dependencies; used by every other file of the block
`default_nettype none

package lslb_pkg;

    localparam int CLK_W      = 32;
    localparam int RSSI_W     = 9;
    localparam int DUR_W      = 24;
    localparam int IVL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // pattern period range reaches 4000 ms, so 12 bits hold any phase
    localparam int PATTERN_PERIOD_MS_DEF = 2000;
    localparam int PHASE_W               = 12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CLK_W-1:0]         t_clk;
    typedef logic signed [RSSI_W-1:0] t_rssi;
    typedef logic [DUR_W-1:0]         t_dur;
    typedef logic [IVL_W-1:0]         t_ivl;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_PACKET = 2'd1,
        OP_IDENT  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        LINK_NONE   = 2'd0,
        LINK_WEAK   = 2'd1,
        LINK_MEDIUM = 2'd2,
        LINK_GOOD   = 2'd3
    } t_link;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEARTBEAT    = 3'd0,
        CFG_IDENT_DEF    = 3'd1,
        CFG_GOOD_THR     = 3'd2,
        CFG_MEDIUM_THR   = 3'd3,
        CFG_GOOD_IVL     = 3'd4,
        CFG_MEDIUM_IVL   = 3'd5,
        CFG_LOW_IVL      = 3'd6,
        CFG_NO_LINK_IVL  = 3'd7
    } t_cfg_idx;

    localparam t_dur  HEARTBEAT_DEF   = 24'd1000;
    localparam t_dur  IDENT_DEF_DEF   = 24'd10000;
    localparam t_rssi GOOD_THR_DEF    = -9'sd80;
    localparam t_rssi MEDIUM_THR_DEF  = -9'sd100;
    localparam t_ivl  GOOD_IVL_DEF    = 16'd5000;
    localparam t_ivl  MEDIUM_IVL_DEF  = 16'd3000;
    localparam t_ivl  LOW_IVL_DEF     = 16'd1000;
    localparam t_ivl  NO_LINK_IVL_DEF = 16'd150;

    // six lit windows of 120 ms within the identify period
    localparam logic [PHASE_W-1:0] WIN0_END = 12'd120;
    localparam logic [PHASE_W-1:0] WIN1_BEG = 12'd240;
    localparam logic [PHASE_W-1:0] WIN1_END = 12'd360;
    localparam logic [PHASE_W-1:0] WIN2_BEG = 12'd480;
    localparam logic [PHASE_W-1:0] WIN2_END = 12'd600;
    localparam logic [PHASE_W-1:0] WIN3_BEG = 12'd980;
    localparam logic [PHASE_W-1:0] WIN3_END = 12'd1100;
    localparam logic [PHASE_W-1:0] WIN4_BEG = 12'd1220;
    localparam logic [PHASE_W-1:0] WIN4_END = 12'd1340;
    localparam logic [PHASE_W-1:0] WIN5_BEG = 12'd1460;
    localparam logic [PHASE_W-1:0] WIN5_END = 12'd1580;

    // one queued command, already decoded by the front
    typedef struct packed {
        t_op   op;
        t_rssi rssi;
        t_dur  dur;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    function automatic logic pattern_on(input logic [PHASE_W-1:0] t);
        pattern_on = (t < WIN0_END) ||
                     (t >= WIN1_BEG && t < WIN1_END) ||
                     (t >= WIN2_BEG && t < WIN2_END) ||
                     (t >= WIN3_BEG && t < WIN3_END) ||
                     (t >= WIN4_BEG && t < WIN4_END) ||
                     (t >= WIN5_BEG && t < WIN5_END);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/lslb_if.sv]
// lslb_in_if, lslb_out_if: valid/ready channels of the LED blinker
// depends on lslb_pkg for the payload types
`default_nettype none

interface lslb_in_if
    import lslb_pkg::*;
;
    logic  valid;
    logic  ready;
    t_op   operation;
    t_rssi rssi;
    t_dur  duration_ms;

    modport source (output valid, operation, rssi, duration_ms, input ready);
    modport sink   (input valid, operation, rssi, duration_ms, output ready);
endinterface

interface lslb_out_if
    import lslb_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  led_lit;
    logic  identify_running;
    t_link link_class;

    modport source (output valid, led_lit, identify_running, link_class, input ready);
    modport sink   (input valid, led_lit, identify_running, link_class, output ready);
endinterface

`default_nettype wire

[hw/rtl/lslb_front.sv]
// lslb_front: accepts input items, decodes them and resolves the identify duration
// depends on lslb_pkg and lslb_in_if
`default_nettype none

module lslb_front
    import lslb_pkg::*;
(
    lslb_in_if.sink    in_ch,
    input  var t_dur   i_ident_def,
    input  var logic   i_q_full,
    output var logic   o_push,
    output var t_cmd   o_cmd
);

    assign in_ch.ready = !i_q_full;
    assign o_push      = in_ch.valid && !i_q_full;

    always_comb begin
        o_cmd.op   = in_ch.operation;
        o_cmd.rssi = in_ch.rssi;
        // zero duration falls back to the default register
        o_cmd.dur  = (in_ch.duration_ms == '0) ? i_ident_def : in_ch.duration_ms;
    end

endmodule

`default_nettype wire

[hw/rtl/lslb_queue.sv]
// lslb_queue: short command queue between front and back
// depends on lslb_pkg
`default_nettype none

module lslb_queue
    import lslb_pkg::*;
(
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var logic      i_push,
    input  var t_cmd      i_cmd,
    input  var logic      i_pop,
    output var t_cmd      o_cmd,
    output var t_q_status o_status
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rd_ptr];
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

[hw/rtl/lslb_back.sv]
// lslb_back: runs queued commands against the blinker state, holds the result register
// depends on lslb_pkg and lslb_out_if
`default_nettype none

module lslb_back
    import lslb_pkg::*;
#(
    parameter int PatternPeriodMs = PATTERN_PERIOD_MS_DEF
) (
    input  var logic      i_clk,
    input  var logic      i_rst_n,
    input  var t_q_status i_q_status,
    input  var t_cmd      i_cmd,
    output var logic      o_pop,
    input  var t_dur      i_heartbeat,
    input  var t_rssi     i_good_thr,
    input  var t_rssi     i_medium_thr,
    input  var t_ivl      i_good_ivl,
    input  var t_ivl      i_medium_ivl,
    input  var t_ivl      i_low_ivl,
    input  var t_ivl      i_no_link_ivl,
    lslb_out_if.source    out_ch
);

    localparam int PhW = $clog2(PatternPeriodMs);
    localparam logic [PhW-1:0] PhaseLast = PhW'(PatternPeriodMs - 1);

    t_clk           r_clock,       n_clock;
    logic           r_pkt_seen,    n_pkt_seen;
    t_clk           r_last_pkt,    n_last_pkt;
    t_rssi          r_last_rssi,   n_last_rssi;
    t_clk           r_last_toggle, n_last_toggle;
    logic           r_led,         n_led;
    logic           r_ident,       n_ident;
    t_clk           r_ident_end,   n_ident_end;
    logic [PhW-1:0] r_phase,       n_phase;

    logic  r_out_valid;
    logic  r_out_led;
    logic  r_out_ident;
    t_link r_out_link;

    t_clk  tick_clock;
    t_clk  end_diff;
    t_clk  alive_limit;
    t_link tick_link;
    t_link res_link;
    t_ivl  interval;
    logic  led_base;

    function automatic t_link classify(input logic seen, input t_clk now, input t_clk pkt,
                                       input t_rssi rssi, input t_clk limit,
                                       input t_rssi good_thr, input t_rssi medium_thr);
        t_clk age;
        age = now - pkt;
        if (!seen || age > limit) begin
            classify = LINK_NONE;
        end else if (rssi >= good_thr) begin
            classify = LINK_GOOD;
        end else if (rssi >= medium_thr) begin
            classify = LINK_MEDIUM;
        end else begin
            classify = LINK_WEAK;
        end
    endfunction

    assign o_pop       = !i_q_status.empty && (!r_out_valid || out_ch.ready);
    assign alive_limit = {{(CLK_W-DUR_W-1){1'b0}}, i_heartbeat, 1'b0};
    assign tick_clock  = r_clock + 1'b1;
    assign tick_link   = classify(r_pkt_seen, tick_clock, r_last_pkt, r_last_rssi,
                                  alive_limit, i_good_thr, i_medium_thr);

    always_comb begin
        case (tick_link)
            LINK_GOOD:   interval = i_good_ivl;
            LINK_MEDIUM: interval = i_medium_ivl;
            LINK_WEAK:   interval = i_low_ivl;
            default:     interval = i_no_link_ivl;
        endcase
    end

    always_comb begin
        n_clock       = r_clock;
        n_pkt_seen    = r_pkt_seen;
        n_last_pkt    = r_last_pkt;
        n_last_rssi   = r_last_rssi;
        n_last_toggle = r_last_toggle;
        n_led         = r_led;
        n_ident       = r_ident;
        n_ident_end   = r_ident_end;
        n_phase       = r_phase;
        end_diff      = tick_clock - r_ident_end;
        led_base      = r_led;
        unique case (i_cmd.op)
            OP_TICK: begin
                n_clock = tick_clock;
                n_phase = (r_phase == PhaseLast) ? '0 : r_phase + 1'b1;
                if (r_ident && end_diff[CLK_W-1]) begin
                    n_led = pattern_on(PHASE_W'(n_phase));
                end else begin
                    // no identify, or identify just ran out (led base goes dark): normal blinking
                    if (r_ident) begin
                        n_ident     = 1'b0;
                        n_ident_end = '0;
                        led_base    = 1'b0;
                    end
                    n_led = led_base;
                    if ((tick_clock - r_last_toggle) >= {{(CLK_W-IVL_W){1'b0}}, interval}) begin
                        n_last_toggle = tick_clock;
                        n_led         = !led_base;
                    end
                end
            end
            OP_PACKET: begin
                n_last_pkt  = r_clock;
                n_last_rssi = i_cmd.rssi;
                n_pkt_seen  = 1'b1;
            end
            OP_IDENT: begin
                n_last_toggle = r_clock;
                n_phase       = '0;
                // a zero duration ends the pattern at once
                if (i_cmd.dur == '0) begin
                    n_ident     = 1'b0;
                    n_ident_end = '0;
                    n_led       = 1'b0;
                end else begin
                    n_ident     = 1'b1;
                    n_ident_end = r_clock + {{(CLK_W-DUR_W){1'b0}}, i_cmd.dur};
                    n_led       = pattern_on('0);
                end
            end
            default: begin
            end
        endcase
        res_link = classify(n_pkt_seen, n_clock, n_last_pkt, n_last_rssi,
                            alive_limit, i_good_thr, i_medium_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock       <= '0;
            r_pkt_seen    <= 1'b0;
            r_last_pkt    <= '0;
            r_last_rssi   <= '0;
            r_last_toggle <= '0;
            r_led         <= 1'b0;
            r_ident       <= 1'b0;
            r_ident_end   <= '0;
            r_phase       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_clock       <= n_clock;
                r_pkt_seen    <= n_pkt_seen;
                r_last_pkt    <= n_last_pkt;
                r_last_rssi   <= n_last_rssi;
                r_last_toggle <= n_last_toggle;
                r_led         <= n_led;
                r_ident       <= n_ident;
                r_ident_end   <= n_ident_end;
                r_phase       <= n_phase;
                r_out_valid   <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_led   <= n_led;
            r_out_ident <= n_ident;
            r_out_link  <= res_link;
        end
    end

    assign out_ch.valid            = r_out_valid;
    assign out_ch.led_lit          = r_out_led;
    assign out_ch.identify_running = r_out_ident;
    assign out_ch.link_class       = r_out_link;

endmodule

`default_nettype wire

[hw/rtl/link_status_led_blinker_top.sv]
// Link status LED blinker. Items are millisecond ticks, packet reports and identify
// triggers; each gives one result with the LED level, the identify flag and the link
// class. Items are taken one per clock cycle while the queue is not full: the front
// decodes an item into a four-entry queue; the back runs one queued item per cycle
// while the result register is free or read, in one state update that loads it; an
// item is queued, popped and registered; the queue absorbs output stalls. The identify
// pattern period is set by PATTERN_PERIOD_MS. Write configuration only while idle.
// depends on lslb_pkg, lslb_if, lslb_front, lslb_queue and lslb_back
`default_nettype none

module link_status_led_blinker_top
    import lslb_pkg::*;
#(
    parameter int PATTERN_PERIOD_MS = PATTERN_PERIOD_MS_DEF
) (
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    lslb_in_if.sink                   i_in,
    lslb_out_if.source                o_out,
    input  var logic                  i_cfg_we,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  var logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dur  r_heartbeat;
    t_dur  r_ident_def;
    t_rssi r_good_thr;
    t_rssi r_medium_thr;
    t_ivl  r_good_ivl;
    t_ivl  r_medium_ivl;
    t_ivl  r_low_ivl;
    t_ivl  r_no_link_ivl;

    logic      push;
    logic      pop;
    t_cmd      cmd_in;
    t_cmd      cmd_out;
    t_q_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heartbeat   <= HEARTBEAT_DEF;
            r_ident_def   <= IDENT_DEF_DEF;
            r_good_thr    <= GOOD_THR_DEF;
            r_medium_thr  <= MEDIUM_THR_DEF;
            r_good_ivl    <= GOOD_IVL_DEF;
            r_medium_ivl  <= MEDIUM_IVL_DEF;
            r_low_ivl     <= LOW_IVL_DEF;
            r_no_link_ivl <= NO_LINK_IVL_DEF;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEARTBEAT:   r_heartbeat   <= i_cfg_data[DUR_W-1:0];
                CFG_IDENT_DEF:   r_ident_def   <= i_cfg_data[DUR_W-1:0];
                CFG_GOOD_THR:    r_good_thr    <= i_cfg_data[RSSI_W-1:0];
                CFG_MEDIUM_THR:  r_medium_thr  <= i_cfg_data[RSSI_W-1:0];
                CFG_GOOD_IVL:    r_good_ivl    <= i_cfg_data[IVL_W-1:0];
                CFG_MEDIUM_IVL:  r_medium_ivl  <= i_cfg_data[IVL_W-1:0];
                CFG_LOW_IVL:     r_low_ivl     <= i_cfg_data[IVL_W-1:0];
                CFG_NO_LINK_IVL: r_no_link_ivl <= i_cfg_data[IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lslb_front u_front (
        .in_ch       (i_in),
        .i_ident_def (r_ident_def),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_cmd       (cmd_in)
    );

    lslb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd_in),
        .i_pop    (pop),
        .o_cmd    (cmd_out),
        .o_status (q_status)
    );

    lslb_back #(
        .PatternPeriodMs (PATTERN_PERIOD_MS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_cmd         (cmd_out),
        .o_pop         (pop),
        .i_heartbeat   (r_heartbeat),
        .i_good_thr    (r_good_thr),
        .i_medium_thr  (r_medium_thr),
        .i_good_ivl    (r_good_ivl),
        .i_medium_ivl  (r_medium_ivl),
        .i_low_ivl     (r_low_ivl),
        .i_no_link_ivl (r_no_link_ivl),
        .out_ch        (o_out)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a full queue takes nothing more
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !i_in.ready)
        else $error("input taken while queue full");

    // a waiting command reaches a free result register in the next cycle
    a_back_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_status.empty && !o_out.valid) |=> o_out.valid)
        else $error("queued command not executed");

endmodule

`default_nettype wire
